FILE: rtl/record_odd_even_transposition_sort_assert.svh
// Assertion macros used by the checker file of the record sorter.
// Depends on nothing.
`ifndef RECORD_ODD_EVEN_TRANSPOSITION_SORT_ASSERT_SVH
`define RECORD_ODD_EVEN_TRANSPOSITION_SORT_ASSERT_SVH
`define ROETS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ROETS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/roets_pkg.sv
// Package of the record sorter: record type, sizes, controller states, command and status types, record compare.
// Depends on nothing.
`default_nettype none
package roets_pkg;
   localparam int MaxRecords = 16;
   localparam int IdxW = $clog2(MaxRecords);
   localparam int CntW = $clog2(MaxRecords + 1);

   typedef struct packed {
      logic [63:0] name_key;
      logic [63:0] job_text;
      logic [4:0]  birth_day;
      logic [3:0]  birth_month;
      logic [13:0] birth_year;
      logic [6:0]  years_in_job;
      logic [30:0] salary;
   } record_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic store;
      logic phase_start;
      logic step;
      logic emit_start;
      logic emit_next;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic phase_done;
      logic last_phase;
      logic emit_last;
   } status_type;

   function automatic logic rec_greater(input record_type a, input record_type b);
      logic res;
      if (a.name_key != b.name_key) begin
         res = a.name_key > b.name_key;
      end else if (a.birth_year != b.birth_year) begin
         res = a.birth_year > b.birth_year;
      end else begin
         res = a.salary > b.salary;
      end
      return res;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/roets_datapath.sv
// Datapath of the record sorter: record registers, one compare-swap unit,
// counters for records, pair, phase and emission, overflow flag. Depends on roets_pkg.
`default_nettype none
module roets_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire roets_pkg::cmd_type      cmd,
   input  wire roets_pkg::record_type   in_rec,
   output roets_pkg::status_type        status,
   output roets_pkg::record_type        out_rec,
   output logic                         out_overflow
);
   roets_pkg::record_type rec_ff [roets_pkg::MaxRecords];
   logic [roets_pkg::CntW-1:0] count_ff, count_in;
   logic [roets_pkg::CntW-1:0] phase_ff, phase_in;
   logic [roets_pkg::CntW-1:0] pair_ff, pair_in;
   logic [roets_pkg::IdxW-1:0] emit_ff, emit_in;
   logic overflow_ff, overflow_in;
   logic full;
   logic [roets_pkg::CntW-1:0] pair_next;
   logic swap_en;

   assign full = count_ff == roets_pkg::CntW'(roets_pkg::MaxRecords);
   assign pair_next = pair_ff + roets_pkg::CntW'(2);
   assign swap_en = cmd.step && (pair_ff + roets_pkg::CntW'(1) < count_ff) &&
      roets_pkg::rec_greater(rec_ff[pair_ff[roets_pkg::IdxW-1:0]],
                             rec_ff[pair_ff[roets_pkg::IdxW-1:0] + 1'b1]);

   always_comb begin
      count_in = count_ff;
      overflow_in = overflow_ff;
      phase_in = phase_ff;
      pair_in = pair_ff;
      emit_in = emit_ff;
      if (cmd.store) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + roets_pkg::CntW'(1);
         end
      end
      if (cmd.phase_start) begin
         pair_in = {{(roets_pkg::CntW-1){1'b0}}, phase_ff[0]};
      end else if (cmd.step) begin
         pair_in = pair_next;
         if (pair_next + roets_pkg::CntW'(1) >= count_ff) begin
            phase_in = phase_ff + roets_pkg::CntW'(1);
         end
      end
      if (cmd.emit_start) begin
         emit_in = '0;
      end else if (cmd.emit_next) begin
         emit_in = emit_ff + 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
         overflow_in = 1'b0;
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         overflow_ff <= 1'b0;
         phase_ff <= '0;
         pair_ff <= '0;
         emit_ff <= '0;
      end else begin
         count_ff <= count_in;
         overflow_ff <= overflow_in;
         phase_ff <= phase_in;
         pair_ff <= pair_in;
         emit_ff <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && !full) begin
         rec_ff[count_ff[roets_pkg::IdxW-1:0]] <= in_rec;
      end
      if (swap_en) begin
         rec_ff[pair_ff[roets_pkg::IdxW-1:0]] <=
            rec_ff[pair_ff[roets_pkg::IdxW-1:0] + 1'b1];
         rec_ff[pair_ff[roets_pkg::IdxW-1:0] + 1'b1] <=
            rec_ff[pair_ff[roets_pkg::IdxW-1:0]];
      end
   end

   assign status.phase_done = pair_next + roets_pkg::CntW'(1) >= count_ff;
   assign status.last_phase = phase_ff >= count_ff;
   assign status.emit_last = roets_pkg::CntW'(emit_ff) + roets_pkg::CntW'(1) == count_ff;
   assign out_rec = rec_ff[emit_ff];
   assign out_overflow = overflow_ff;
endmodule
`default_nettype wire

FILE: rtl/roets_ctrl.sv
// Controller of the record sorter: load, sort phases and emission sequencing.
// Depends on roets_pkg.
`default_nettype none
module roets_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_final,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire roets_pkg::status_type  status,
   output roets_pkg::cmd_type          cmd
);
   roets_pkg::state_type state_ff, state_in;
   logic starting_ff, starting_in;

   always_comb begin
      state_in = state_ff;
      starting_in = starting_ff;
      unique case (state_ff)
         roets_pkg::ST_LOAD: begin
            if (req_valid && req_final) begin
               state_in = roets_pkg::ST_SORT;
               starting_in = 1'b1;
            end
         end
         roets_pkg::ST_SORT: begin
            if (starting_ff) begin
               starting_in = 1'b0;
               if (status.last_phase) begin
                  state_in = roets_pkg::ST_EMIT;
               end
            end else if (status.phase_done) begin
               starting_in = 1'b1;
            end
         end
         roets_pkg::ST_EMIT: begin
            if (rsp_ready && status.emit_last) begin
               state_in = roets_pkg::ST_LOAD;
            end
         end
         default: state_in = roets_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         roets_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
            cmd.emit_start = 1'b1;
         end
         roets_pkg::ST_SORT: begin
            if (starting_ff) begin
               cmd.phase_start = !status.last_phase;
            end else begin
               cmd.step = 1'b1;
            end
         end
         roets_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit_next = rsp_ready;
            cmd.clear = rsp_ready && status.emit_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= roets_pkg::ST_LOAD;
         starting_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         starting_ff <= starting_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/record_odd_even_transposition_sort.sv
// A final beat with n records is followed by the sort phases, then n result
// beats. Records are compared one pair at a time by the single compare-swap unit;
// no new records are accepted until the run has been emitted.
// Reset clears the record count, overflow flag and controller; stores are not cleared.
`default_nettype none
module record_odd_even_transposition_sort (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_name_key,
   input  wire logic [63:0] req_job_text,
   input  wire logic [4:0]  req_birth_day,
   input  wire logic [3:0]  req_birth_month,
   input  wire logic [13:0] req_birth_year,
   input  wire logic [6:0]  req_years_in_job,
   input  wire logic [30:0] req_salary,
   input  wire logic        req_final_record,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_out_name_key,
   output logic [63:0]      rsp_out_job_text,
   output logic [4:0]       rsp_out_birth_day,
   output logic [3:0]       rsp_out_birth_month,
   output logic [13:0]      rsp_out_birth_year,
   output logic [6:0]       rsp_out_years_in_job,
   output logic [30:0]      rsp_out_salary,
   output logic             rsp_end_of_run,
   output logic             rsp_overflowed
);
   roets_pkg::cmd_type cmd;
   roets_pkg::status_type status;
   roets_pkg::record_type in_rec, out_rec;

   assign in_rec = '{req_name_key, req_job_text, req_birth_day, req_birth_month,
                     req_birth_year, req_years_in_job, req_salary};

   roets_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_final(req_final_record), .req_ready,
      .rsp_valid, .rsp_ready, .status, .cmd
   );

   roets_datapath u_dp (
      .clock, .reset, .cmd, .in_rec, .status, .out_rec, .out_overflow(rsp_overflowed)
   );

   assign rsp_out_name_key = out_rec.name_key;
   assign rsp_out_job_text = out_rec.job_text;
   assign rsp_out_birth_day = out_rec.birth_day;
   assign rsp_out_birth_month = out_rec.birth_month;
   assign rsp_out_birth_year = out_rec.birth_year;
   assign rsp_out_years_in_job = out_rec.years_in_job;
   assign rsp_out_salary = out_rec.salary;
   assign rsp_end_of_run = status.emit_last;
endmodule
`default_nettype wire

FILE: rtl/roets_checker.sv
// Port-level checker of the record sorter and its bind to the top level.
// Depends on record_odd_even_transposition_sort_assert.svh.
`default_nettype none
`include "record_odd_even_transposition_sort_assert.svh"
module roets_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_end_of_run,
   input wire logic rsp_overflowed
);
   `ROETS_ASSERT_IMP(no_overlap, clock, reset, rsp_valid, !req_ready)
   `ROETS_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ROETS_ASSERT_NEXT(run_ends, clock, reset, rsp_valid && rsp_ready && rsp_end_of_run, !rsp_valid)
   `ROETS_ASSERT_NEXT(ovf_steady, clock, reset, rsp_valid && rsp_ready && !rsp_end_of_run, $stable(rsp_overflowed))
endmodule
bind record_odd_even_transposition_sort roets_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_end_of_run, .rsp_overflowed
);
`default_nettype wire
